// ----- hw/rtl/ftds_pkg.sv -----
// Shared types and constants for the frame time drift smoother.
package ftds_pkg;

    localparam int WINDOW_DEPTH = 16;

    localparam int TIME_W  = 40;
    localparam int NOM_W   = 48;
    localparam int FD_W    = 24;
    localparam int TOL_W   = 24;
    localparam int DELTA_W = 41;
    localparam int RES_W   = NOM_W + 1;

    localparam logic [TOL_W-1:0] TOL_RESET = 24'd100000;

    localparam logic REQ_RAW    = 1'b0;
    localparam logic REQ_SMOOTH = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [TIME_W-1:0] now_time;
        logic [FD_W-1:0]   frame_delta;
    } t_in_item;

    typedef struct packed {
        logic signed [DELTA_W-1:0] delta_out;
        logic                      resynced;
    } t_out_item;

endpackage

// ----- hw/rtl/ftds_alu.sv -----
// Shared add/subtract unit used by the arithmetic steps of the sequencer.
module ftds_alu #(
    parameter int W = 56
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic         i_sub,
    output logic [W-1:0] o_y
);

    assign o_y = i_sub ? (i_a - i_b) : (i_a + i_b);

endmodule

// ----- hw/rtl/ftds_diff_ram.sv -----
// Circular record store of (nominal - real) offsets, registered read.
module ftds_diff_ram #(
    parameter int DEPTH  = 16,
    parameter int W      = 48,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [W-1:0]      i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [W-1:0]      o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/frame_time_drift_smoother.sv -----
// Frame time smoother: sequencer, state registers and output stage.
// A raw item runs S_RAW then S_OUT; a smoothed item runs the steps S_NOM to S_CMP, plus
// S_FIX on a resync, then S_OUT. SUM_W = 49 + clog2(WINDOW_DEPTH) quotient bits come from
// the bit-serial division of the window sum by the record count on the shared adder. The
// next item is taken in the cycle after the result is loaded, later while the output
// register stays full. Synchronous active-low reset clears state; tolerance resets to 100000.
module frame_time_drift_smoother #(
    parameter int WINDOW_DEPTH = ftds_pkg::WINDOW_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ftds_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ftds_pkg::t_out_item           o_out_item,
    input  logic                          i_cfg_we,
    input  logic [ftds_pkg::TOL_W-1:0]    i_cfg_wdata
);

    localparam int NOM_W  = ftds_pkg::NOM_W;
    localparam int TIME_W = ftds_pkg::TIME_W;
    localparam int RES_W  = ftds_pkg::RES_W;
    localparam int DLT_W  = ftds_pkg::DELTA_W;
    localparam int SUM_W  = 49 + $clog2(WINDOW_DEPTH);
    localparam int AW     = SUM_W + 1;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int ITER_W = $clog2(SUM_W + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_RAW, S_NOM, S_DIFF, S_ADD, S_SUBOLD, S_DIVINIT, S_DIV,
        S_NEG, S_SMOOTH, S_RES, S_EDIFF, S_ESUM, S_EABS, S_CMP, S_FIX, S_OUT
    } t_state;

    t_state                       r_state;
    ftds_pkg::t_in_item           r_item;
    logic [ftds_pkg::TOL_W-1:0]   r_tol;
    logic [TIME_W-1:0]            r_last;
    logic [NOM_W-1:0]             r_nominal;
    logic [NOM_W-1:0]             r_smoothed;
    logic [NOM_W-1:0]             r_err;
    logic [NOM_W-1:0]             r_diff;
    logic [NOM_W-1:0]             r_mean;
    logic [NOM_W-1:0]             r_new;
    logic [NOM_W-1:0]             r_mag;
    logic [SUM_W-1:0]             r_sum;
    logic [SUM_W-1:0]             r_quo;
    logic [CNT_W-1:0]             r_rem;
    logic [CNT_W-1:0]             r_count;
    logic [ADDR_W-1:0]            r_head;
    logic [ITER_W-1:0]            r_iter;
    logic                         r_full;
    logic                         r_neg;
    logic                         r_resync;
    logic [RES_W-1:0]             r_res;
    logic                         r_out_valid;
    ftds_pkg::t_out_item          r_out_item;

    logic [AW-1:0]      alu_a;
    logic [AW-1:0]      alu_b;
    logic               alu_sub;
    logic [AW-1:0]      alu_y;
    logic [CNT_W:0]     trial;
    logic               ge;
    logic               ram_we;
    logic [NOM_W-1:0]   ram_wdata;
    logic [NOM_W-1:0]   ram_rdata;
    logic [ADDR_W-1:0]  head_nxt;
    logic [DLT_W-1:0]   sat_res;

    function automatic logic [AW-1:0] sx48(input logic [NOM_W-1:0] v);
        return {{(AW-NOM_W){v[NOM_W-1]}}, v};
    endfunction

    assign trial = {r_rem, r_quo[SUM_W-1]};
    assign ge    = ~alu_y[AW-1];

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            S_RAW: begin
                alu_a   = AW'(r_item.now_time);
                alu_b   = AW'(r_last);
                alu_sub = 1'b1;
            end
            S_NOM: begin
                alu_a = AW'(r_nominal);
                alu_b = AW'(r_item.frame_delta);
            end
            S_DIFF: begin
                alu_a   = AW'(r_nominal);
                alu_b   = AW'(r_item.now_time);
                alu_sub = 1'b1;
            end
            S_ADD: begin
                alu_a = {r_sum[SUM_W-1], r_sum};
                alu_b = sx48(r_diff);
            end
            S_SUBOLD: begin
                alu_a   = {r_sum[SUM_W-1], r_sum};
                alu_b   = r_full ? sx48(ram_rdata) : '0;
                alu_sub = 1'b1;
            end
            S_DIVINIT: begin
                alu_b   = {r_sum[SUM_W-1], r_sum};
                alu_sub = 1'b1;
            end
            S_DIV: begin
                alu_a   = AW'(trial);
                alu_b   = AW'(r_count);
                alu_sub = 1'b1;
            end
            S_NEG: begin
                alu_a   = r_neg ? '0 : AW'(r_quo);
                alu_b   = r_neg ? AW'(r_quo) : '0;
                alu_sub = r_neg;
            end
            S_SMOOTH: begin
                alu_a = AW'(r_item.now_time);
                alu_b = sx48(r_mean);
            end
            S_RES: begin
                alu_a   = AW'(r_new);
                alu_b   = AW'(r_smoothed);
                alu_sub = 1'b1;
            end
            S_EDIFF: begin
                alu_a   = AW'(r_nominal);
                alu_b   = AW'(r_new);
                alu_sub = 1'b1;
            end
            S_ESUM: begin
                alu_a = AW'(r_err);
                alu_b = AW'(r_diff);
            end
            S_EABS: begin
                alu_b   = sx48(r_err);
                alu_sub = 1'b1;
            end
            S_CMP: begin
                alu_a   = AW'(r_tol);
                alu_b   = AW'(r_mag);
                alu_sub = 1'b1;
            end
            S_FIX: begin
                alu_a = {{(AW-RES_W){r_res[RES_W-1]}}, r_res};
                alu_b = sx48(r_err);
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    ftds_alu #(
        .W (AW)
    ) u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_y   (alu_y)
    );

    assign ram_we    = (r_state == S_DIFF) || (r_state == S_FIX);
    assign ram_wdata = (r_state == S_FIX) ? '0 : alu_y[NOM_W-1:0];
    assign head_nxt  = (r_head == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : r_head + ADDR_W'(1);

    ftds_diff_ram #(
        .DEPTH  (WINDOW_DEPTH),
        .W      (NOM_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_head),
        .i_wdata (ram_wdata),
        .i_re    (r_state == S_NOM),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (r_res[RES_W-1:DLT_W-1] == {(RES_W-DLT_W+1){r_res[RES_W-1]}}) begin
            sat_res = r_res[DLT_W-1:0];
        end else if (r_res[RES_W-1]) begin
            sat_res = {1'b1, {(DLT_W-1){1'b0}}};
        end else begin
            sat_res = {1'b0, {(DLT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tol       <= ftds_pkg::TOL_RESET;
            r_last      <= '0;
            r_nominal   <= '0;
            r_smoothed  <= '0;
            r_err       <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_head      <= '0;
            r_resync    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item   <= i_in_item;
                        r_resync <= 1'b0;
                        r_state  <= (i_in_item.req_type == ftds_pkg::REQ_RAW) ? S_RAW : S_NOM;
                    end
                end
                S_RAW: begin
                    r_res      <= alu_y[RES_W-1:0];
                    r_last     <= r_item.now_time;
                    r_nominal  <= NOM_W'(r_item.now_time);
                    r_smoothed <= NOM_W'(r_item.now_time);
                    r_err      <= '0;
                    r_count    <= '0;
                    r_sum      <= '0;
                    r_state    <= S_OUT;
                end
                S_NOM: begin
                    r_nominal <= alu_y[NOM_W-1:0];
                    r_last    <= r_item.now_time;
                    r_full    <= (r_count == CNT_W'(WINDOW_DEPTH));
                    r_state   <= S_DIFF;
                end
                S_DIFF: begin
                    r_diff  <= alu_y[NOM_W-1:0];
                    r_head  <= head_nxt;
                    if (!r_full) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_sum   <= alu_y[SUM_W-1:0];
                    r_state <= S_SUBOLD;
                end
                S_SUBOLD: begin
                    r_sum   <= alu_y[SUM_W-1:0];
                    r_state <= S_DIVINIT;
                end
                S_DIVINIT: begin
                    r_neg   <= r_sum[SUM_W-1];
                    r_quo   <= r_sum[SUM_W-1] ? alu_y[SUM_W-1:0] : r_sum;
                    r_rem   <= '0;
                    r_iter  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= ge ? alu_y[CNT_W-1:0] : trial[CNT_W-1:0];
                    r_quo  <= {r_quo[SUM_W-2:0], ge};
                    r_iter <= r_iter + ITER_W'(1);
                    if (r_iter == ITER_W'(SUM_W - 1)) begin
                        r_state <= S_NEG;
                    end
                end
                S_NEG: begin
                    r_mean  <= alu_y[NOM_W-1:0];
                    r_state <= S_SMOOTH;
                end
                S_SMOOTH: begin
                    r_new   <= alu_y[NOM_W-1:0];
                    r_state <= S_RES;
                end
                S_RES: begin
                    r_res      <= {alu_y[NOM_W-1], alu_y[NOM_W-1:0]};
                    r_smoothed <= r_new;
                    r_state    <= S_EDIFF;
                end
                S_EDIFF: begin
                    r_diff  <= alu_y[NOM_W-1:0];
                    r_state <= S_ESUM;
                end
                S_ESUM: begin
                    r_err   <= alu_y[NOM_W-1:0];
                    r_state <= S_EABS;
                end
                S_EABS: begin
                    r_mag   <= r_err[NOM_W-1] ? alu_y[NOM_W-1:0] : r_err;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_state <= alu_y[AW-1] ? S_FIX : S_OUT;
                end
                S_FIX: begin
                    r_res      <= alu_y[RES_W-1:0];
                    r_last     <= r_item.now_time;
                    r_nominal  <= NOM_W'(r_item.now_time);
                    r_smoothed <= NOM_W'(r_item.now_time);
                    r_err      <= '0;
                    r_sum      <= '0;
                    r_count    <= CNT_W'(1);
                    r_head     <= head_nxt;
                    r_resync   <= 1'b1;
                    r_state    <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid          <= 1'b1;
                        r_out_item.delta_out <= sat_res;
                        r_out_item.resynced  <= r_resync;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(WINDOW_DEPTH))
        else $error("record count above window depth");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("accepted item not taken into work");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_count))
        else $error("division remainder not below record count");

    a_resync_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_resync) |-> (r_count == CNT_W'(1)))
        else $error("resync did not restart the window");
`endif

endmodule
